/* hw/rtl/gmma_pkg.sv */
package gmma_pkg;

  localparam logic [63:0] GlP   = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] GlEps = 64'h0000_0000_FFFF_FFFF;

  // register stages inside the multiply-reduce pipeline
  localparam int MulLat = 5;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_MAC  = 2'd1,
    OP_MSUB = 2'd2,
    OP_ADD  = 2'd3
  } op_t;

  // sideband that rides along with the product
  typedef struct packed {
    op_t         op;
    logic [63:0] a;
    logic [63:0] acc;
  } side_t;

  typedef struct packed {
    logic  vld;
    side_t side;
  } ctl_t;

  function automatic logic [63:0] canon(input logic [63:0] x);
    canon = (x >= GlP) ? (x - GlP) : x;
  endfunction

  function automatic logic [63:0] add_p(input logic [63:0] x, input logic [63:0] y);
    add_p = ((GlP - x) > y) ? (x + y) : (x + y - GlP);
  endfunction

  function automatic logic [63:0] sub_p(input logic [63:0] x, input logic [63:0] y);
    sub_p = (x >= y) ? (x - y) : (GlP - y + x);
  endfunction

endpackage

/* hw/rtl/gmma_mul_red.sv */
module gmma_mul_red (
  input  logic           clk,
  input  logic           rst_n,
  input  gmma_pkg::ctl_t ctl_i,
  input  logic [63:0]    x_i,
  input  logic [63:0]    y_i,
  output gmma_pkg::ctl_t ctl_o,
  output logic [63:0]    prod_o
);
  import gmma_pkg::*;

  logic              vld_r [MulLat];
  side_t             side_r [MulLat];

  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [63:0] lo_r, hi_r;
  logic [63:0] t0_r, t1_r;
  logic [63:0] r_r;
  logic [63:0] m_r;

  logic [33:0] mid;
  logic [63:0] lo_nxt, hi_nxt;
  logic [31:0] hh, hl;
  logic [63:0] t0_nxt, t1_nxt;
  logic [64:0] sum;
  logic [63:0] r_nxt;

  // partial-product column sums
  always_comb begin
    mid    = {2'b0, p00_r[63:32]} + {2'b0, p01_r[31:0]} + {2'b0, p10_r[31:0]};
    lo_nxt = {mid[31:0], p00_r[31:0]};
    hi_nxt = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]} + {62'b0, mid[33:32]};
  end

  // fold: 2^96 = -1 and 2^64 = 2^32 - 1 mod p
  always_comb begin
    hh     = hi_r[63:32];
    hl     = hi_r[31:0];
    t0_nxt = lo_r - {32'b0, hh};
    if (lo_r < {32'b0, hh}) begin
      t0_nxt = t0_nxt - GlEps;
    end
    t1_nxt = {hl, 32'b0} - {32'b0, hl};
  end

  always_comb begin
    sum   = {1'b0, t0_r} + {1'b0, t1_r};
    r_nxt = sum[63:0] + (sum[64] ? GlEps : 64'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MulLat; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= ctl_i.vld;
      for (int i = 1; i < MulLat; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= ctl_i.side;
    for (int i = 1; i < MulLat; i++) begin
      side_r[i] <= side_r[i-1];
    end
    p00_r <= {32'b0, x_i[31:0]}  * {32'b0, y_i[31:0]};
    p01_r <= {32'b0, x_i[31:0]}  * {32'b0, y_i[63:32]};
    p10_r <= {32'b0, x_i[63:32]} * {32'b0, y_i[31:0]};
    p11_r <= {32'b0, x_i[63:32]} * {32'b0, y_i[63:32]};
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    r_r   <= r_nxt;
    m_r   <= canon(r_r);
  end

  assign ctl_o.vld  = vld_r[MulLat-1];
  assign ctl_o.side = side_r[MulLat-1];
  assign prod_o     = m_r;

endmodule

/* hw/rtl/goldilocks_mod_mul_acc.sv */
// Goldilocks (p = 2^64 - 2^32 + 1) multiply-accumulate, fully pipelined.
// Throughput: one transaction per cycle; busy stays low, set by the seven
//   register stages (input, five multiply-reduce, output), none of which holds.
// Reset: synchronous, active low; clears all valid bits, data regs keep junk.
// The receiver cannot stall: out_strobe lasts exactly one cycle per result.
module goldilocks_mod_mul_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [63:0]         in_a_in,
  input  logic [63:0]         in_b_in,
  input  logic [63:0]         in_acc_in,
  output logic                out_strobe,
  output logic [63:0]         out_value_out
);
  import gmma_pkg::*;

  localparam int Lat = MulLat + 2;

  // Stage 0: canonicalize operands once at the input.
  logic        vld0_r;
  side_t       side0_r;
  logic [63:0] x0_r, y0_r;

  ctl_t        ctl0;
  ctl_t        mul_ctl;
  logic [63:0] prod;

  logic        strobe_r;
  logic [63:0] value_r;
  logic [63:0] value_nxt;

  // The pipeline advances every cycle, so a new transaction is always taken.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    side0_r.op  <= op_t'(in_op);
    side0_r.a   <= canon(in_a_in);
    side0_r.acc <= canon(in_acc_in);
    x0_r        <= canon(in_a_in);
    y0_r        <= canon(in_b_in);
  end

  assign ctl0.vld  = vld0_r;
  assign ctl0.side = side0_r;

  // Stages 1..5: 128-bit product reduced mod p, sideband carried alongside.
  gmma_mul_red u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl0),
    .x_i    (x0_r),
    .y_i    (y0_r),
    .ctl_o  (mul_ctl),
    .prod_o (prod)
  );

  // Final stage: combine the product, or operand a for OP_ADD, with the accumulator.
  always_comb begin
    case (mul_ctl.side.op)
      OP_MUL:  value_nxt = prod;
      OP_MAC:  value_nxt = add_p(mul_ctl.side.acc, prod);
      OP_MSUB: value_nxt = sub_p(mul_ctl.side.acc, prod);
      OP_ADD:  value_nxt = add_p(mul_ctl.side.a, mul_ctl.side.acc);
      default: value_nxt = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= mul_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_value_out = value_r;

`ifndef SYNTH
  // every accepted transaction comes out as a result strobe once it has passed the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##Lat out_strobe)
    else $error("result missing after accepted transaction");

  // no result without a matching earlier transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, Lat))
    else $error("result without a transaction");

  // results are always canonical residues
  a_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_value_out < GlP))
    else $error("result not below p");

  // multiply-reduce output feeds the output register in the next cycle
  a_mul_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl.vld |=> out_strobe)
    else $error("product lost before output stage");
`endif

endmodule

/* dv/goldilocks_mod_mul_acc_checker.sv */
module goldilocks_mod_mul_acc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_a_in,
  input  logic [63:0] in_b_in,
  input  logic [63:0] in_acc_in,
  input  logic        out_strobe,
  input  logic [63:0] out_value_out,
  output int unsigned errors,
  output int unsigned pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import gmma_pkg::*;

  localparam logic [63:0] PRIME = 64'hFFFF_FFFF_0000_0001;

  typedef struct {
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] acc;
    logic [63:0] value;
  } coeff_txn_t;

  coeff_txn_t  expected_coeffs[$];
  coeff_txn_t  oldest;
  coeff_txn_t  fresh;
  int unsigned mismatch_count = 0;
  int unsigned queued_count = 0;

  assign errors  = mismatch_count;
  assign pending = queued_count;

  // one subtraction is enough: 2^64 < 2p
  function automatic logic [63:0] reduce_once(input logic [63:0] x);
    reduce_once = (x >= PRIME) ? x - PRIME : x;
  endfunction

  function automatic logic [63:0] field_result(input op_t op, input logic [63:0] a,
                                               input logic [63:0] b,
                                               input logic [63:0] acc);
    logic [63:0]  x;
    logic [63:0]  y;
    logic [63:0]  z;
    logic [63:0]  prod;
    logic [127:0] wide;
    logic [64:0]  sum;
    x    = reduce_once(a);
    y    = reduce_once(b);
    z    = reduce_once(acc);
    wide = {64'd0, x} * {64'd0, y};
    prod = 64'(wide % {64'd0, PRIME});
    case (op)
      OP_MUL:  field_result = prod;
      OP_MAC: begin
        sum = {1'b0, z} + {1'b0, prod};
        field_result = (sum >= {1'b0, PRIME}) ? 64'(sum - {1'b0, PRIME}) : sum[63:0];
      end
      OP_MSUB: field_result = (z >= prod) ? z - prod : (PRIME - prod) + z;
      default: begin
        sum = {1'b0, z} + {1'b0, x};
        field_result = (sum >= {1'b0, PRIME}) ? 64'(sum - {1'b0, PRIME}) : sum[63:0];
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count, what);
  endtask

  // retire first, then queue, so a result never matches the transaction
  // accepted on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_coeffs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_value_out));
        end else begin
          oldest = expected_coeffs.pop_front();
          if (out_value_out !== oldest.value) begin
            report_mismatch($sformatf("%s a=%h b=%h acc=%h: got %h, want %h",
                                      oldest.op.name(), oldest.a, oldest.b, oldest.acc,
                                      out_value_out, oldest.value));
          end
        end
      end
      if (start && !busy) begin
        fresh.op    = op_t'(in_op);
        fresh.a     = in_a_in;
        fresh.b     = in_b_in;
        fresh.acc   = in_acc_in;
        fresh.value = field_result(fresh.op, in_a_in, in_b_in, in_acc_in);
        expected_coeffs.push_back(fresh);
      end
      queued_count = expected_coeffs.size();
    end
  end

endmodule

/* dv/goldilocks_mod_mul_acc_test.sv */
module goldilocks_mod_mul_acc_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gmma_pkg::*;

  localparam realtime     CLK_PERIOD   = 12ns;
  localparam int          RESET_CYCLES = 12;
  localparam int          RANDOM_TXNS  = 1400;
  // pipeline is 7 deep; leave plenty of room for the tail
  localparam int          DRAIN_CYCLES = 30;
  // slowest legal run is roughly 1.4k transactions, each followed by the longest gap
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  localparam logic [63:0] PRIME    = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] PRIME_M1 = PRIME - 64'd1;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TWO_32   = 64'h0000_0001_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [63:0] in_a_in;
  logic [63:0] in_b_in;
  logic [63:0] in_acc_in;
  logic        out_strobe;
  logic [63:0] out_value_out;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  goldilocks_mod_mul_acc u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_a_in      (in_a_in),
    .in_b_in      (in_b_in),
    .in_acc_in    (in_acc_in),
    .out_strobe   (out_strobe),
    .out_value_out(out_value_out)
  );

  goldilocks_mod_mul_acc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_a_in      (in_a_in),
    .in_b_in      (in_b_in),
    .in_acc_in    (in_acc_in),
    .out_strobe   (out_strobe),
    .out_value_out(out_value_out),
    .errors       (errors),
    .pending      (pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** goldilocks_mod_mul_acc: FAILED **");
      $finish;
    end
  end

  // Present one transaction and hold it until the edge that takes it.
  // start stays high on return so back-to-back calls never lower it.
  task automatic send(input op_t op, input logic [63:0] a, input logic [63:0] b,
                      input logic [63:0] acc);
    start     <= 1'b1;
    in_op     <= op;
    in_a_in   <= a;
    in_b_in   <= b;
    in_acc_in <= acc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a while and scramble the payload so stale fields
  // cannot leak into the next transaction.
  task automatic idle(input int cycles);
    start     <= 1'b0;
    in_op     <= 2'($urandom);
    in_a_in   <= {$urandom, $urandom};
    in_b_in   <= {$urandom, $urandom};
    in_acc_in <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  // Mostly uniform residues, with a share of corner values, small values,
  // values just below p and non-canonical values at or above p.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    int          kind;
    kind = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (kind < 68) begin
      if (v >= PRIME) v = v - PRIME;
    end else if (kind < 78) begin
      case ($urandom_range(0, 9))
        0:       v = 64'd0;
        1:       v = 64'd1;
        2:       v = 64'd2;
        3:       v = PRIME_M1;
        4:       v = PRIME - 64'd2;
        5:       v = TWO_32;
        6:       v = TWO_32 - 64'd1;
        7:       v = PRIME;
        8:       v = ALL_ONES;
        default: v = 64'h8000_0000_0000_0000;
      endcase
    end else if (kind < 88) begin
      v = 64'($urandom_range(0, 255));
    end else if (kind < 94) begin
      v = PRIME_M1 - 64'($urandom_range(0, 1000));
    end else begin
      // every value above p differs from p only in its low 32 bits
      v = PRIME + 64'($urandom_range(0, 32'hFFFF_FFFE));
    end
    return v;
  endfunction

  // Most gaps are zero or short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int burst_left;
    int gap;
    burst_left = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_op     <= OP_MUL;
    in_a_in   <= 64'd0;
    in_b_in   <= 64'd0;
    in_acc_in <= 64'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    idle($urandom_range(1, 4));

    // Directed corners, back to back: products that wrap through 2^64 and
    // 2^96, sums and differences that wrap around p, non-canonical operands
    // and unused operands carrying junk.
    send(OP_MUL,  64'd0,        64'd0,                  ALL_ONES);
    send(OP_MUL,  PRIME_M1,     PRIME_M1,               64'd0);
    send(OP_MUL,  PRIME_M1,     64'd2,                  64'd5);
    send(OP_MUL,  TWO_32,       TWO_32,                 64'd0);
    send(OP_MUL,  64'h1_0000_0000_0000, 64'h1_0000_0000_0000, 64'd0);
    send(OP_MUL,  ALL_ONES,     ALL_ONES,               PRIME);
    send(OP_MUL,  PRIME,        64'd12345,              64'd7);
    send(OP_MUL,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'd0);
    send(OP_MAC,  64'd1,        64'd1,                  PRIME_M1);
    send(OP_MAC,  PRIME_M1,     PRIME_M1,               PRIME_M1);
    send(OP_MAC,  64'd0,        64'hDEAD_BEEF_0BAD_F00D, ALL_ONES);
    send(OP_MAC,  ALL_ONES,     ALL_ONES,               ALL_ONES);
    send(OP_MSUB, 64'd1,        64'd1,                  64'd0);
    send(OP_MSUB, 64'd0,        64'd0,                  64'd0);
    send(OP_MSUB, PRIME_M1,     PRIME_M1,               PRIME_M1);
    send(OP_MSUB, ALL_ONES,     64'd5,                  PRIME);
    send(OP_MSUB, TWO_32 - 64'd1, TWO_32 + 64'd1,       64'd0);
    send(OP_ADD,  PRIME_M1,     ALL_ONES,               PRIME_M1);
    send(OP_ADD,  64'd1,        64'd0,                  PRIME_M1);
    send(OP_ADD,  ALL_ONES,     64'd123,                ALL_ONES);
    send(OP_ADD,  64'd0,        64'd0,                  64'd0);
    send(OP_ADD,  PRIME,        ALL_ONES,               PRIME);
    idle(pick_gap() + 1);

    // Random traffic with occasional gap-free bursts.
    for (int n = 0; n < RANDOM_TXNS; n++) begin
      send(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(), pick_operand());
      if (burst_left == 0 && $urandom_range(0, 9) == 0) burst_left = $urandom_range(20, 80);
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) idle(gap);
    end
    idle(1);

    // Drain: wait out every queued result, then let the pipeline settle so
    // a stray late strobe still gets caught.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("** goldilocks_mod_mul_acc: PASSED **");
    end else begin
      $display("** goldilocks_mod_mul_acc: FAILED **");
    end
    $finish;
  end

endmodule
